// ===== rtl/fqsr_pkg.sv =====
// ----------------------------------------------------------------------------
// fqsr_pkg: shared types and constants of the searchable queue
// Holds the sizes, the command codes, the status codes and the cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package fqsr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 16;

    // fixed payload widths
    localparam int OPCODE_W  = 3;
    localparam int PROC_ID_W = 16;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 24;

    // derived sizes
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [OPCODE_W-1:0] {
        OP_ENQUEUE  = 3'd0,
        OP_DEQUEUE  = 3'd1,
        OP_PEEK     = 3'd2,
        OP_CONTAINS = 3'd3,
        OP_REMOVE   = 3'd4,
        OP_CLEAR    = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    // control broadcast to every cell
    typedef struct packed {
        logic                shift_en;   // take the neighbor's entry where the hit chain is set
        logic                load_en;    // write cmp_id into the cell at the tail
        logic [ID_WIDTH-1:0] cmp_id;     // identifier to compare or to load
        logic [CNT_W-1:0]    count;      // current number of entries
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/fifo_queue_with_search_remove_top.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_search_remove_top: bounded queue of ids with search and remove
// Enqueue, dequeue, peek, contains, remove-first-match and clear over a row of cells.
// ----------------------------------------------------------------------------
// a command's result is registered in the output register when the item is accepted
// throughput: one item per cycle while the output drains; every cell compares at once
//   and a single shift along the row closes a gap, so no command iterates
// the input is taken while a finished result waits, as long as that result leaves in the same cycle
// reset: aresetn low at a clock edge empties the queue and drops any pending result;
//   slot contents are not cleared
`default_nettype none

module fifo_queue_with_search_remove_top
    import fqsr_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // [2:0] opcode, [18:3] proc_id, rest zero

    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata    // [15:0] id_out, [16] found, [18:17] status,
                                                // [23:19] occupancy
);

    // input unpack
    logic [OPCODE_W-1:0]  opcode;
    logic [PROC_ID_W-1:0] proc_id;
    logic                 accept;

    assign opcode  = s_tdata[OPCODE_W-1:0];
    assign proc_id = s_tdata[OPCODE_W +: PROC_ID_W];

    // state
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_DATA_W-1:0] out_data_next;

    // cell row
    cell_ctrl_t          ctrl;
    logic [QUEUE_DEPTH:0] hit_chain;
    logic [ID_WIDTH-1:0] cell_data [QUEUE_DEPTH];

    // per-command result
    logic [ID_WIDTH-1:0] res_id;
    logic                res_found;
    status_t             res_status;
    logic                is_empty;
    logic                is_full;
    logic                any_hit;

    // a new item enters whenever the output register is free or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign is_empty = count_reg == '0;
    assign is_full  = count_reg == CNT_W'(QUEUE_DEPTH);
    // last link of the chain: some cell in range matched (only meaningful without a forced head hit)
    assign any_hit  = hit_chain[QUEUE_DEPTH];

    // dequeue forces the hit at the head so the whole row shifts by one
    assign hit_chain[0] = opcode == OP_DEQUEUE;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic [ID_WIDTH-1:0] nbr;
            if (gi == QUEUE_DEPTH - 1) begin : g_last
                // nothing beyond the tail: the last slot keeps what it has
                assign nbr = cell_data[gi];
            end else begin : g_mid
                assign nbr = cell_data[gi + 1];
            end
            fqsr_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .cell_idx  (IDX_W'(gi)),
                .hit_in    (hit_chain[gi]),
                .next_data (nbr),
                .hit_out   (hit_chain[gi + 1]),
                .data      (cell_data[gi])
            );
        end
    endgenerate

    // command decode: cell control, result fields and next count
    always_comb begin
        ctrl.shift_en = 1'b0;
        ctrl.load_en  = 1'b0;
        ctrl.cmp_id   = ID_WIDTH'(proc_id);
        ctrl.count    = count_reg;
        res_id        = '0;
        res_found     = 1'b0;
        res_status    = ST_OK;
        count_next    = count_reg;
        unique case (opcode)
            OP_ENQUEUE: begin
                if (is_full) begin
                    res_status = ST_FULL;
                end else begin
                    ctrl.load_en = accept;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            OP_DEQUEUE, OP_PEEK: begin
                if (is_empty) begin
                    res_status = ST_EMPTY;
                end else begin
                    res_id = cell_data[0];
                    if (opcode == OP_DEQUEUE) begin
                        ctrl.shift_en = accept;
                        count_next    = count_reg - CNT_W'(1);
                    end
                end
            end
            OP_CONTAINS, OP_REMOVE: begin
                if (any_hit) begin
                    res_found = 1'b1;
                    if (opcode == OP_REMOVE) begin
                        // cells from the first match upward take their neighbor's entry
                        ctrl.shift_en = accept;
                        count_next    = count_reg - CNT_W'(1);
                    end
                end else begin
                    res_status = ST_MISSING;
                end
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
                // unused codes: no change, plain ok result
            end
        endcase
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept) begin
            out_valid_next = 1'b1;
            out_data_next  = {OCC_W'(count_next), res_status, res_found, PROC_ID_W'(res_id)};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // occupancy never exceeds the number of cells
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // every accepted item leaves a result in the output register
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> out_valid_reg)
        else $error("accepted item produced no result");

    // a dequeue on a non-empty queue drops the count by one
    a_dequeue_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && opcode == OP_DEQUEUE && !is_empty) |=>
            count_reg == $past(count_reg) - CNT_W'(1))
        else $error("dequeue count mismatch");

    // a reported match always carries an ok status
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[PROC_ID_W]) |->
            out_data_reg[PROC_ID_W+1 +: STATUS_W] == ST_OK)
        else $error("found with non-ok status");

endmodule

`default_nettype wire

// ===== rtl/fqsr_cell.sv =====
// ----------------------------------------------------------------------------
// fqsr_cell: one queue slot
// Compares its entry, extends the first-hit chain, shifts toward the head and loads at the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module fqsr_cell
    import fqsr_pkg::*;
(
    input  wire logic                aclk,
    input  wire cell_ctrl_t          ctrl,
    input  wire logic [IDX_W-1:0]    cell_idx,
    input  wire logic                hit_in,
    input  wire logic [ID_WIDTH-1:0] next_data,
    output logic                     hit_out,
    output logic [ID_WIDTH-1:0]      data
);

    logic [ID_WIDTH-1:0] data_reg;
    logic [ID_WIDTH-1:0] data_next;
    logic                in_range;
    logic                hit_here;
    logic                at_tail;

    assign in_range = CNT_W'(cell_idx) < ctrl.count;
    assign at_tail  = CNT_W'(cell_idx) == ctrl.count;
    // hit is set at the first match and stays set for every later cell
    assign hit_here = hit_in || (in_range && (data_reg == ctrl.cmp_id));
    assign hit_out  = hit_here;
    assign data     = data_reg;

    always_comb begin
        data_next = data_reg;
        if (ctrl.shift_en && hit_here) begin
            data_next = next_data;
        end else if (ctrl.load_en && at_tail) begin
            data_next = ctrl.cmp_id;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire
